/* src/ipim_pkg.sv */
// Shared types and constants for the interprocessor interrupt mailbox.
// Holds command, status, reason and counter codes and the queue entry type.
// No dependencies.
package ipim_pkg;

   localparam logic [1:0] CMD_POST     = 2'd0;
   localparam logic [1:0] CMD_DISPATCH = 2'd1;
   localparam logic [1:0] CMD_QUERY    = 2'd2;

   localparam logic [2:0] ST_REJECTED   = 3'd0;
   localparam logic [2:0] ST_COALESCED  = 3'd1;
   localparam logic [2:0] ST_NOTIFY     = 3'd2;
   localparam logic [2:0] ST_DISPATCHED = 3'd3;
   localparam logic [2:0] ST_EMPTY      = 3'd4;
   localparam logic [2:0] ST_QUERY      = 3'd5;
   localparam logic [2:0] ST_BAD_CPU    = 3'd6;

   localparam logic [3:0] REASON_ALL       = 4'hF;
   localparam logic [3:0] REASON_RESCHED   = 4'h1;
   localparam logic [3:0] REASON_SHOOTDOWN = 4'h2;
   localparam logic [3:0] REASON_STOP      = 4'h4;
   localparam logic [3:0] REASON_DEADLINE  = 4'h8;

   localparam logic CSR_ONLINE  = 1'b0;
   localparam logic CSR_STARTED = 1'b1;

   localparam int NUM_COUNTERS  = 8;
   localparam int CNT_POSTED    = 0;
   localparam int CNT_COALESCED = 1;
   localparam int CNT_NOTIFY    = 2;
   localparam int CNT_DISPATCH  = 3;
   localparam int CNT_RESCHED   = 4;
   localparam int CNT_SHOOTDOWN = 5;
   localparam int CNT_DEADLINE  = 6;
   localparam int CNT_HALT      = 7;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [2:0] {
      OP_POST,
      OP_DISPATCH,
      OP_QUERY,
      OP_REJECT,
      OP_REJECT_BAD,
      OP_BAD_CPU
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] target;
      logic [3:0] bits;
   } entry_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_EXEC
   } back_state_type;

endpackage

/* src/ipim_front.sv */
// Front end: holds the availability registers and classifies each request.
// Depends on ipim_pkg.
module ipim_front import ipim_pkg::*; #(
   parameter int NUM_CPUS = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_cmd,
   input  logic [7:0] req_target_cpu,
   input  logic [7:0] req_reason_bits,
   input  logic       queue_full,
   output logic       push,
   output entry_type  push_entry
);

   logic [7:0] online_ff;
   logic [7:0] started_ff;
   logic       tgt_ok;
   logic       avail;
   logic       mask_ok;
   logic       post_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         online_ff  <= '0;
         started_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ONLINE:  online_ff  <= csr_wdata;
            CSR_STARTED: started_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      tgt_ok  = {1'b0, req_target_cpu} < 9'(NUM_CPUS);
      mask_ok = (req_reason_bits != '0) &&
                ((req_reason_bits & ~8'(REASON_ALL)) == '0);
      if (req_target_cpu >= 8'd8) begin
         avail = 1'b0;
      end else if (req_reason_bits == 8'(REASON_STOP)) begin
         avail = started_ff[req_target_cpu[2:0]];
      end else begin
         avail = online_ff[req_target_cpu[2:0]];
      end
      post_ok = (req_cmd == CMD_POST) && mask_ok && tgt_ok && avail;

      push_entry.target = req_target_cpu;
      push_entry.bits   = req_reason_bits[3:0];
      case (req_cmd)
         CMD_DISPATCH: push_entry.op = tgt_ok ? OP_DISPATCH : OP_BAD_CPU;
         CMD_QUERY:    push_entry.op = tgt_ok ? OP_QUERY : OP_BAD_CPU;
         default: begin
            if (post_ok) begin
               push_entry.op = OP_POST;
            end else begin
               push_entry.op = tgt_ok ? OP_REJECT : OP_REJECT_BAD;
            end
         end
      endcase
   end

   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;

endmodule

/* src/ipim_queue.sv */
// Short queue of classified transactions between the front and back ends.
// Depends on ipim_pkg.
module ipim_queue import ipim_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output entry_type head,
   output logic      full,
   output logic      empty
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               do_push;
   logic               do_pop;

   assign full    = count_ff == CNT_W'(QUEUE_DEPTH);
   assign empty   = count_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

/* src/ipim_back.sv */
// Back end: reads a processor's mailbox row, updates pending bits and counters,
// writes the row back and registers the response. Depends on ipim_pkg.
module ipim_back import ipim_pkg::*; #(
   parameter int NUM_CPUS    = 8,
   parameter int COUNT_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  entry_type   head,
   input  logic        empty,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [3:0]  rsp_reasons,
   output logic [31:0] rsp_posted_count,
   output logic [31:0] rsp_coalesced_count,
   output logic [31:0] rsp_notify_count,
   output logic [31:0] rsp_dispatch_count,
   output logic [31:0] rsp_resched_count,
   output logic [31:0] rsp_shootdown_count,
   output logic [31:0] rsp_deadline_count,
   output logic [31:0] rsp_halt_count
);

   localparam int IDX_W = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
   localparam int ROW_W = 4 + NUM_COUNTERS * COUNT_WIDTH;

   back_state_type           state_ff;
   back_state_type           state_in;
   entry_type                cur_ff;
   logic [ROW_W-1:0]         mem [NUM_CPUS];
   logic [NUM_CPUS-1:0]      row_vld_ff;
   logic [ROW_W-1:0]         rd_data_ff;
   logic                     rd_vld_ff;
   logic [IDX_W-1:0]         rd_idx;
   logic [IDX_W-1:0]         wr_idx;
   logic                     exec_fire;
   logic                     wr_en;
   logic                     wr_need;
   logic [ROW_W-1:0]         wr_row;
   logic [3:0]               pend_cur;
   logic [3:0]               pend_new;
   logic [COUNT_WIDTH-1:0]   cnt_cur [NUM_COUNTERS];
   logic [COUNT_WIDTH-1:0]   cnt_new [NUM_COUNTERS];
   logic [NUM_COUNTERS-1:0]  inc;
   logic [2:0]               status_c;
   logic [3:0]               reasons_c;
   logic                     show;
   logic                     rsp_valid_ff;
   logic [2:0]               status_ff;
   logic [3:0]               reasons_ff;
   logic [31:0]              out_cnt_ff [NUM_COUNTERS];

   always_comb begin
      case (state_ff)
         BACK_IDLE: state_in = empty ? BACK_IDLE : BACK_EXEC;
         BACK_EXEC: state_in = exec_fire ? BACK_IDLE : BACK_EXEC;
         default:   state_in = BACK_IDLE;
      endcase
   end

   always_comb begin
      pop       = 1'b0;
      exec_fire = 1'b0;
      case (state_ff)
         BACK_IDLE: pop       = !empty;
         BACK_EXEC: exec_fire = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= head;
      end
   end

   assign rd_idx = (head.op == OP_BAD_CPU || head.op == OP_REJECT_BAD) ?
                   '0 : head.target[IDX_W-1:0];
   assign wr_idx = cur_ff.target[IDX_W-1:0];
   assign wr_en  = exec_fire && wr_need;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_row;
      end
      if (pop) begin
         rd_data_ff <= mem[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_vld_ff <= '0;
         rd_vld_ff  <= 1'b0;
      end else begin
         if (wr_en) begin
            row_vld_ff[wr_idx] <= 1'b1;
         end
         if (pop) begin
            rd_vld_ff <= row_vld_ff[rd_idx];
         end
      end
   end

   always_comb begin
      pend_cur = rd_vld_ff ? rd_data_ff[3:0] : '0;
      for (int k = 0; k < NUM_COUNTERS; k++) begin
         cnt_cur[k] = rd_vld_ff ? rd_data_ff[4 + k * COUNT_WIDTH +: COUNT_WIDTH] : '0;
      end
      inc       = '0;
      pend_new  = pend_cur;
      status_c  = ST_REJECTED;
      reasons_c = pend_cur;
      show      = 1'b1;
      wr_need   = 1'b0;
      case (cur_ff.op)
         OP_POST: begin
            pend_new          = pend_cur | cur_ff.bits;
            inc[CNT_POSTED]   = 1'b1;
            wr_need           = 1'b1;
            reasons_c         = pend_new;
            if ((pend_cur & cur_ff.bits) == cur_ff.bits) begin
               inc[CNT_COALESCED] = 1'b1;
               status_c           = ST_COALESCED;
            end else begin
               inc[CNT_NOTIFY] = 1'b1;
               status_c        = ST_NOTIFY;
            end
         end
         OP_DISPATCH: begin
            pend_new = '0;
            wr_need  = 1'b1;
            if (pend_cur == '0) begin
               status_c = ST_EMPTY;
            end else begin
               status_c          = ST_DISPATCHED;
               inc[CNT_DISPATCH] = 1'b1;
               if ((pend_cur & REASON_STOP) != '0) begin
                  inc[CNT_HALT] = 1'b1;
               end else begin
                  inc[CNT_RESCHED]   = (pend_cur & REASON_RESCHED) != '0;
                  inc[CNT_SHOOTDOWN] = (pend_cur & REASON_SHOOTDOWN) != '0;
                  inc[CNT_DEADLINE]  = (pend_cur & REASON_DEADLINE) != '0;
               end
            end
         end
         OP_QUERY:  status_c = ST_QUERY;
         OP_REJECT: status_c = ST_REJECTED;
         OP_REJECT_BAD: begin
            status_c  = ST_REJECTED;
            reasons_c = '0;
            show      = 1'b0;
         end
         OP_BAD_CPU: begin
            status_c  = ST_BAD_CPU;
            reasons_c = '0;
            show      = 1'b0;
         end
         default: begin
            status_c  = ST_BAD_CPU;
            reasons_c = '0;
            show      = 1'b0;
         end
      endcase
      wr_row[3:0] = pend_new;
      for (int k = 0; k < NUM_COUNTERS; k++) begin
         cnt_new[k] = cnt_cur[k] + COUNT_WIDTH'(inc[k]);
         wr_row[4 + k * COUNT_WIDTH +: COUNT_WIDTH] = cnt_new[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (exec_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_fire) begin
         status_ff  <= status_c;
         reasons_ff <= reasons_c;
         for (int k = 0; k < NUM_COUNTERS; k++) begin
            out_cnt_ff[k] <= show ? 32'(cnt_new[k]) : '0;
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = status_ff;
   assign rsp_reasons         = reasons_ff;
   assign rsp_posted_count    = out_cnt_ff[CNT_POSTED];
   assign rsp_coalesced_count = out_cnt_ff[CNT_COALESCED];
   assign rsp_notify_count    = out_cnt_ff[CNT_NOTIFY];
   assign rsp_dispatch_count  = out_cnt_ff[CNT_DISPATCH];
   assign rsp_resched_count   = out_cnt_ff[CNT_RESCHED];
   assign rsp_shootdown_count = out_cnt_ff[CNT_SHOOTDOWN];
   assign rsp_deadline_count  = out_cnt_ff[CNT_DEADLINE];
   assign rsp_halt_count      = out_cnt_ff[CNT_HALT];

endmodule

/* src/ipi_mailbox_coalescer.sv */
// Interprocessor interrupt mailbox with per-processor pending reasons and counters.
// A transaction accepted on an idle block passes through a queue slot, the registered
// read of its mailbox row and the response register. The back end takes one transaction
// at a time, writing its row back before the next row is read; rsp_ready stalls it.
// Reset is synchronous and clears the queue, the masks and all mailbox rows at once.
// Depends on ipim_pkg, ipim_front, ipim_queue and ipim_back.
module ipi_mailbox_coalescer import ipim_pkg::*; #(
   parameter int NUM_CPUS    = 8,
   parameter int COUNT_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_target_cpu,
   input  logic [7:0]  req_reason_bits,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [3:0]  rsp_reasons,
   output logic [31:0] rsp_posted_count,
   output logic [31:0] rsp_coalesced_count,
   output logic [31:0] rsp_notify_count,
   output logic [31:0] rsp_dispatch_count,
   output logic [31:0] rsp_resched_count,
   output logic [31:0] rsp_shootdown_count,
   output logic [31:0] rsp_deadline_count,
   output logic [31:0] rsp_halt_count
);

   logic      push;
   entry_type push_entry;
   logic      pop;
   entry_type head;
   logic      full;
   logic      empty;

   ipim_front #(
      .NUM_CPUS(NUM_CPUS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_target_cpu  (req_target_cpu),
      .req_reason_bits (req_reason_bits),
      .queue_full      (full),
      .push            (push),
      .push_entry      (push_entry)
   );

   ipim_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .full       (full),
      .empty      (empty)
   );

   ipim_back #(
      .NUM_CPUS    (NUM_CPUS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .head                (head),
      .empty               (empty),
      .pop                 (pop),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_reasons         (rsp_reasons),
      .rsp_posted_count    (rsp_posted_count),
      .rsp_coalesced_count (rsp_coalesced_count),
      .rsp_notify_count    (rsp_notify_count),
      .rsp_dispatch_count  (rsp_dispatch_count),
      .rsp_resched_count   (rsp_resched_count),
      .rsp_shootdown_count (rsp_shootdown_count),
      .rsp_deadline_count  (rsp_deadline_count),
      .rsp_halt_count      (rsp_halt_count)
   );

endmodule
